### sv/square_matrix_multiply_assert.svh
// assertion macros used by square_matrix_multiply.sv
// both expect clk_i and rst_ni in scope
`ifndef SQUARE_MATRIX_MULTIPLY_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_ASSERT_SVH

// same-cycle implication
`define SMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/smm_pkg.sv
`default_nettype none

package smm_pkg;

  localparam int DIM   = 3;
  localparam int CELLS = DIM * DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int EW    = 16;
  localparam int PW    = 2 * EW;
  localparam int RW    = 35;
  localparam int IW    = 3;

  // tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic          valid;
    logic          first;
    logic          lastk;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic          fin;
  } tag_t;

endpackage

`default_nettype wire

### sv/smm_store.sv
`default_nettype none

module smm_store
  import smm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic signed [EW-1:0] a_wdata_i,
  input  wire logic signed [EW-1:0] b_wdata_i,
  input  wire logic [AW-1:0]        a_raddr_i,
  input  wire logic [AW-1:0]        b_raddr_i,
  output logic signed [EW-1:0]      a_rdata_o,
  output logic signed [EW-1:0]      b_rdata_o
);

  logic signed [EW-1:0] mem_a [CELLS];
  logic signed [EW-1:0] mem_b [CELLS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_a[waddr_i] <= a_wdata_i;
      mem_b[waddr_i] <= b_wdata_i;
    end
    a_rdata_o <= mem_a[a_raddr_i];
    b_rdata_o <= mem_b[b_raddr_i];
  end

endmodule

`default_nettype wire

### sv/smm_mac.sv
`default_nettype none

module smm_mac
  import smm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tag_t                 tag_i,
  input  wire logic signed [EW-1:0] a_i,
  input  wire logic signed [EW-1:0] b_i,
  output logic                      valid_o,
  output logic signed [RW-1:0]      prod_o,
  output logic [IW-1:0]             row_o,
  output logic [IW-1:0]             col_o,
  output logic                      last_o
);

  tag_t                 tag_q;
  logic signed [PW-1:0] mul_q;
  logic signed [PW-1:0] mul_d;
  logic signed [RW-1:0] acc_q;
  logic signed [RW-1:0] acc_d;
  logic                 valid_q;
  logic signed [RW-1:0] res_q;
  logic [IW-1:0]        row_q;
  logic [IW-1:0]        col_q;
  logic                 last_q;

  assign mul_d = a_i * b_i;
  // restart the sum on the first term of a dot product
  assign acc_d = (tag_q.first ? '0 : acc_q) + {{(RW-PW){mul_q[PW-1]}}, mul_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tag_q   <= tag_i;
      valid_q <= tag_q.valid && tag_q.lastk;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    if (tag_q.valid) begin
      acc_q <= acc_d;
    end
    if (tag_q.valid && tag_q.lastk) begin
      res_q  <= acc_d;
      row_q  <= tag_q.row;
      col_q  <= tag_q.col;
      last_q <= tag_q.fin;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = res_q;
  assign row_o   = row_q;
  assign col_o   = col_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

### sv/square_matrix_multiply.sv
// loading: one item per cycle while busy is low, no result for all but the last pair
// after the last pair busy stays high until the final result (last_o) has gone out
// results then come out in row-major order, one per dot product of DIM terms, all from one MAC
// a whole pair of matrices is DIM^2 items, 9 items at DIM=3
// results are single-cycle strobes on valid_o, the receiver cannot stall them
// async active-low reset clears the load count and control; stored elements are not cleared
`default_nettype none

`include "square_matrix_multiply_assert.svh"

module square_matrix_multiply
  import smm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [EW-1:0] a_elem_i,
  input  wire logic signed [EW-1:0] b_elem_i,
  output logic                      valid_o,
  output logic signed [RW-1:0]      prod_elem_o,
  output logic [IW-1:0]             out_row_o,
  output logic [IW-1:0]             out_col_o,
  output logic                      last_o
);

  // load phase, issue phase walking i/j/k, then wait for the pipe to empty
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } state_e;

  localparam logic [IW-1:0] IMAX = IW'(DIM - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] load_cnt_q, load_cnt_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW-1:0] k_q, k_d;

  logic          mem_we;
  logic          load_last;
  logic [AW-1:0] a_raddr;
  logic [AW-1:0] b_raddr;
  tag_t          issue_tag;
  tag_t          rd_tag_q;

  logic signed [EW-1:0] a_rdata;
  logic signed [EW-1:0] b_rdata;

  logic                 res_valid;
  logic signed [RW-1:0] res_prod;
  logic [IW-1:0]        res_row;
  logic [IW-1:0]        res_col;
  logic                 res_last;
  logic                 at_corner;

  // row-major addresses: A[i][k] and B[k][j]
  assign a_raddr = AW'(int'(i_q) * DIM + int'(k_q));
  assign b_raddr = AW'(int'(k_q) * DIM + int'(j_q));

  // next pair is the one that completes both matrices
  assign load_last = (load_cnt_q == AW'(CELLS - 1));

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    mem_we     = 1'b0;
    issue_tag  = '0;
    case (state_q)
      ST_LOAD: begin
        if (start) begin
          mem_we = 1'b1;
          // the last pair completes both matrices, start the product
          if (load_last) begin
            load_cnt_d = '0;
            i_d        = '0;
            j_d        = '0;
            k_d        = '0;
            state_d    = ST_RUN;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_RUN: begin
        issue_tag.valid = 1'b1;
        issue_tag.first = (k_q == '0);
        issue_tag.lastk = (k_q == IMAX);
        issue_tag.row   = i_q;
        issue_tag.col   = j_q;
        issue_tag.fin   = (k_q == IMAX) && (j_q == IMAX) && (i_q == IMAX);
        // k innermost, then column, then row
        if (k_q != IMAX) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          if (j_q != IMAX) begin
            j_d = j_q + 1'b1;
          end else begin
            j_d = '0;
            if (i_q == IMAX) begin
              i_d     = '0;
              state_d = ST_DRAIN;
            end else begin
              i_d = i_q + 1'b1;
            end
          end
        end
      end
      ST_DRAIN: begin
        // free again once the final product element has gone out
        if (res_valid && res_last) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      rd_tag_q   <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      // tag follows the registered memory read
      rd_tag_q   <= issue_tag;
    end
  end

  // stores are only written while idle and their read data is only used while busy, so no overlap
  smm_store u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (load_cnt_q),
    .a_wdata_i (a_elem_i),
    .b_wdata_i (b_elem_i),
    .a_raddr_i (a_raddr),
    .b_raddr_i (b_raddr),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata)
  );

  // multiply stage then accumulate stage, result registered
  smm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (rd_tag_q),
    .a_i     (a_rdata),
    .b_i     (b_rdata),
    .valid_o (res_valid),
    .prod_o  (res_prod),
    .row_o   (res_row),
    .col_o   (res_col),
    .last_o  (res_last)
  );

  assign busy        = (state_q != ST_LOAD);
  assign valid_o     = res_valid;
  assign prod_elem_o = res_prod;
  assign out_row_o   = res_row;
  assign out_col_o   = res_col;
  assign last_o      = res_last;

  // bottom-right corner of the product matrix
  assign at_corner = (out_row_o == IMAX) && (out_col_o == IMAX);

  `SMM_ASSERT_IMP(a_res_while_busy, valid_o, busy, "result outside busy window")
  `SMM_ASSERT_IMP(a_last_corner, valid_o && last_o, at_corner, "last item not at corner")
  `SMM_ASSERT_NXT(a_go_busy, start && !busy && load_last, busy, "final pair did not start product")
  `SMM_ASSERT_NXT(a_free_after_last, valid_o && last_o, !busy, "still busy after last item")

endmodule

`default_nettype wire
